// File: src/length_prefixed_frame_deframer_macros.svh
// assertion macros used by the deframer parser module
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, checked outside reset
`define LPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// File: src/lpfd_pkg.sv
package lpfd_pkg;

    // frame parser phases
    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LEN   = 2'd1,
        PH_BODY  = 2'd2,
        PH_TRAIL = 2'd3
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BODY      = 2'd0,
        KIND_GOOD      = 2'd1,
        KIND_LEN_ERR   = 2'd2,
        KIND_TRAIL_ERR = 2'd3
    } kind_t;

    localparam logic [30:0] MAX_BODY_RESET = 31'd1048576;

    // one result item plus its valid flag
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data;
        logic        last_body;
        logic [30:0] frame_length;
    } result_t;

    // header pattern 01 17 17 01
    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h01;
            2'd1:    b = 8'h17;
            2'd2:    b = 8'h17;
            2'd3:    b = 8'h01;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

    // trailer pattern 04 17 17 04
    function automatic logic [7:0] trl_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h04;
            2'd1:    b = 8'h17;
            2'd2:    b = 8'h17;
            2'd3:    b = 8'h04;
            default: b = 8'h04;
        endcase
        return b;
    endfunction

endpackage

// File: src/lpfd_in_stage.sv
module lpfd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       accept;

    // hold off only when the held byte cannot move on this cycle
    assign in_stall = vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // byte register, loaded on every input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = vld_reg;
    assign byte_data  = byte_reg;

endmodule

// File: src/lpfd_parser.sv
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      byte_data,
    input  logic [30:0]     max_len,
    output lpfd_pkg::result_t res
);

    lpfd_pkg::phase_t  phase_reg;
    lpfd_pkg::phase_t  phase_next;
    logic [1:0]        match_reg;
    logic [1:0]        match_next;
    logic [31:0]       len_reg;
    logic [31:0]       len_next;
    logic [30:0]       remain_reg;
    logic [30:0]       remain_next;
    logic [31:0]       len_full;
    logic              len_bad;
    logic              in_body;
    logic              body_more;
    logic              last_out;
    logic              len_err_out;
    logic              trail_start;
    logic              hunt_clear;

    // length as complete once the fourth byte arrives
    assign len_full = {byte_data, len_reg[23:0]};
    assign len_bad  = (len_full == 32'd0) || len_full[31] || (len_full[30:0] > max_len);

    // next state and result for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        match_next  = match_reg;
        len_next    = len_reg;
        remain_next = remain_reg;

        res.valid        = 1'b0;
        res.kind         = lpfd_pkg::KIND_BODY;
        res.data         = 8'd0;
        res.last_body    = 1'b0;
        res.frame_length = len_reg[30:0];

        case (phase_reg)
            lpfd_pkg::PH_HUNT:
            begin
                if (byte_data == lpfd_pkg::hdr_byte(match_reg))
                begin
                    if (match_reg == 2'd3)
                    begin
                        phase_next = lpfd_pkg::PH_LEN;
                        match_next = 2'd0;
                        len_next   = 32'd0;
                    end
                    else
                    begin
                        match_next = match_reg + 2'd1;
                    end
                end
                else if (byte_data == lpfd_pkg::hdr_byte(2'd0))
                begin
                    match_next = 2'd1;
                end
                else
                begin
                    match_next = 2'd0;
                end
            end

            lpfd_pkg::PH_LEN:
            begin
                case (match_reg)
                    2'd0:    len_next = {len_reg[31:8], byte_data};
                    2'd1:    len_next = {len_reg[31:16], byte_data, len_reg[7:0]};
                    2'd2:    len_next = {len_reg[31:24], byte_data, len_reg[15:0]};
                    default: len_next = len_full;
                endcase
                if (match_reg != 2'd3)
                begin
                    match_next = match_reg + 2'd1;
                end
                else
                begin
                    match_next = 2'd0;
                    if (len_bad)
                    begin
                        phase_next       = lpfd_pkg::PH_HUNT;
                        len_next         = 32'd0;
                        remain_next      = 31'd0;
                        res.valid        = 1'b1;
                        res.kind         = lpfd_pkg::KIND_LEN_ERR;
                        res.frame_length = 31'd0;
                    end
                    else
                    begin
                        remain_next = len_full[30:0];
                        phase_next  = lpfd_pkg::PH_BODY;
                    end
                end
            end

            lpfd_pkg::PH_BODY:
            begin
                res.valid = 1'b1;
                res.kind  = lpfd_pkg::KIND_BODY;
                res.data  = byte_data;
                if (remain_reg <= 31'd1)
                begin
                    res.last_body = 1'b1;
                    remain_next   = 31'd0;
                    phase_next    = lpfd_pkg::PH_TRAIL;
                    match_next    = 2'd0;
                end
                else
                begin
                    remain_next = remain_reg - 31'd1;
                end
            end

            lpfd_pkg::PH_TRAIL:
            begin
                if (byte_data == lpfd_pkg::trl_byte(match_reg))
                begin
                    if (match_reg == 2'd3)
                    begin
                        phase_next = lpfd_pkg::PH_HUNT;
                        match_next = 2'd0;
                        res.valid  = 1'b1;
                        res.kind   = lpfd_pkg::KIND_GOOD;
                    end
                    else
                    begin
                        match_next = match_reg + 2'd1;
                    end
                end
                else
                begin
                    phase_next = lpfd_pkg::PH_HUNT;
                    match_next = 2'd0;
                    res.valid  = 1'b1;
                    res.kind   = lpfd_pkg::KIND_TRAIL_ERR;
                end
            end

            default:
            begin
                phase_next = lpfd_pkg::PH_HUNT;
                match_next = 2'd0;
            end
        endcase
    end

    // parser state, updated once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lpfd_pkg::PH_HUNT;
            match_reg  <= 2'd0;
            len_reg    <= 32'd0;
            remain_reg <= 31'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            match_reg  <= match_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
        end
    end

    // conditions watched by the checks below
    assign in_body     = (phase_reg == lpfd_pkg::PH_BODY);
    assign body_more   = step && in_body && (remain_reg > 31'd1);
    assign last_out    = step && res.valid && res.last_body;
    assign len_err_out = step && res.valid && (res.kind == lpfd_pkg::KIND_LEN_ERR);
    assign trail_start = (phase_reg == lpfd_pkg::PH_TRAIL) && (match_reg == 2'd0);
    assign hunt_clear  = (phase_reg == lpfd_pkg::PH_HUNT) && (len_reg == 32'd0);

    // body count never runs dry while still in the body
    `LPFD_ASSERT_IMPL(a_body_remain_nonzero, clk, rst_n, in_body, remain_reg != 31'd0)
    // a body byte with more to come keeps the parser in the body
    `LPFD_ASSERT_NEXT(a_body_continues, clk, rst_n, body_more, in_body)
    // the last body byte hands over to the trailer check
    `LPFD_ASSERT_NEXT(a_last_to_trailer, clk, rst_n, last_out, trail_start)
    // a length error always reports a zero length and restarts hunting
    `LPFD_ASSERT_NEXT(a_len_err_restart, clk, rst_n, len_err_out, hunt_clear)

endmodule

// File: src/lpfd_out_stage.sv
module lpfd_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lpfd_pkg::result_t res,
    input  logic              out_stall,
    output logic              out_free,
    output logic              out_valid,
    output logic [1:0]        kind,
    output logic [7:0]        data,
    output logic              last_body,
    output logic [30:0]       frame_length
);

    logic              vld_reg;
    logic              vld_next;
    logic              load;
    lpfd_pkg::result_t res_reg;

    // result register can take a new result when empty or being drained
    assign out_free = !vld_reg || !out_stall;
    assign load     = step && res.valid;

    always_comb
    begin
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (vld_reg && !out_stall)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = vld_reg;
    assign kind         = res_reg.kind;
    assign data         = res_reg.data;
    assign last_body    = res_reg.last_body;
    assign frame_length = res_reg.frame_length;

endmodule

// File: src/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer. Takes one received byte per transfer and
// hunts for the header 01 17 17 01, reads a 4-byte little-endian signed body
// length, streams the body bytes out with the last one marked, then checks the
// trailer 04 17 17 04. Results are body bytes, frame good, length error (length
// not positive or above max_body_length) or trailer error; both errors restart
// hunting. A byte is accepted every cycle as long as the result register is not
// held by out_stall; each byte waits in the input register, then the parser
// loads its result into the result register, which drives the outputs. The
// parser state updates once per byte. max_body_length resets to 1048576 and is
// written through the cfg_valid / cfg_ready transfer; the user must write
// it only while idle, as the block itself does not enforce this.
module length_prefixed_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data,
    output logic        last_body,
    output logic [30:0] frame_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] max_body_length
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              out_free;
    logic              step;
    logic [30:0]       max_len_reg;
    lpfd_pkg::result_t res;

    // held byte moves through the parser when the result side has room
    assign step      = byte_valid && out_free;
    assign cfg_ready = 1'b1;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= lpfd_pkg::MAX_BODY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= max_body_length;
        end
    end

    lpfd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    lpfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_data (byte_data),
        .max_len   (max_len_reg),
        .res       (res)
    );

    lpfd_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .res          (res),
        .out_stall    (out_stall),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .kind         (kind),
        .data         (data),
        .last_body    (last_body),
        .frame_length (frame_length)
    );

endmodule
